FILE: hw/rtl/lgen_pkg.sv
// Shared types and constants for the toroidal life generation block.
// Field widths of the stream payloads, item kinds and the B3/S23 counts.
// No dependencies.
package lgen_pkg;

  localparam int KIND_W  = 2;
  localparam int IDX_W   = 4;
  localparam int CELLS_W = 32;
  localparam int TDATA_W = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_STEP  = 2'd2
  } kind_e;

  // Neighbor counts of the B3/S23 rule
  localparam logic [3:0] SURVIVE_CNT = 4'd2;
  localparam logic [3:0] BIRTH_CNT   = 4'd3;

endpackage

FILE: hw/rtl/lgen_mem.sv
// Simple dual-port synchronous memory holding both grid banks.
// One write and one read port, read data registered.
// No dependencies.
module lgen_mem #(
  parameter int AW = 5,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  localparam int Depth = 2 ** AW;

  logic [DW-1:0] mem_q [Depth];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/lgen_rule.sv
// Next-generation row under B3/S23 with wraparound between the edge columns.
// Takes the row above, the row itself and the row below; uses lgen_pkg.
// Purely combinational; the caller registers around it.
module lgen_rule #(
  parameter int COLS = 32
) (
  input  logic [COLS-1:0] row_above_i,
  input  logic [COLS-1:0] row_mid_i,
  input  logic [COLS-1:0] row_below_i,
  output logic [COLS-1:0] row_next_o
);
  import lgen_pkg::*;

  logic [COLS-1:0] above_l, above_r, mid_l, mid_r, below_l, below_r;

  // bit b of *_l holds bit b-1, bit b of *_r holds bit b+1, both wrapping
  assign above_l = {row_above_i[COLS-2:0], row_above_i[COLS-1]};
  assign above_r = {row_above_i[0], row_above_i[COLS-1:1]};
  assign mid_l   = {row_mid_i[COLS-2:0], row_mid_i[COLS-1]};
  assign mid_r   = {row_mid_i[0], row_mid_i[COLS-1:1]};
  assign below_l = {row_below_i[COLS-2:0], row_below_i[COLS-1]};
  assign below_r = {row_below_i[0], row_below_i[COLS-1:1]};

  always_comb begin
    logic [3:0] cnt;
    cnt = '0;
    row_next_o = '0;
    for (int b = 0; b < COLS; b++) begin
      cnt = 4'(row_above_i[b]) + 4'(above_l[b]) + 4'(above_r[b])
          + 4'(mid_l[b]) + 4'(mid_r[b])
          + 4'(row_below_i[b]) + 4'(below_l[b]) + 4'(below_r[b]);
      if (row_mid_i[b]) begin
        row_next_o[b] = (cnt == SURVIVE_CNT) || (cnt == BIRTH_CNT);
      end else begin
        row_next_o[b] = (cnt == BIRTH_CNT);
      end
    end
  end

endmodule

FILE: hw/rtl/toroidal_life_generation.sv
// Life grid (B3/S23 on a torus) with row write, row read and generation step.
// One item at a time; a step reads every row once plus two wrap rows through
// the single memory read port.
// Reset clears per-row valid bits, so the grid reads as zero; no clearing pass.
// Depends on lgen_pkg, lgen_mem and lgen_rule.
module toroidal_life_generation #(
  parameter int COLS = 32,
  parameter int ROWS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [3:0] row_index, [35:4] row_cells, [39:36] zero
  input  logic [lgen_pkg::TDATA_W-1:0] s_axis_tdata,
  // [1:0] kind
  input  logic [lgen_pkg::KIND_W-1:0]  s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [3:0] row_index_out, [35:4] row_data, [39:36] zero
  output logic [lgen_pkg::TDATA_W-1:0] m_axis_tdata
);
  import lgen_pkg::*;

  localparam int AW  = $clog2(ROWS);
  localparam int CW  = $clog2(ROWS + 4);
  localparam int MAW = AW + 1;
  localparam int PadW = TDATA_W - IDX_W - CELLS_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RDATA,
    ST_STEP,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       k_q;
  logic                bank_q;
  logic [ROWS-1:0]     valid_q;
  logic                rvalid_q;
  logic                rd_inrange_q;
  logic [IDX_W-1:0]    res_idx_q;
  logic [CELLS_W-1:0]  res_data_q;
  logic                out_valid_q;
  logic [TDATA_W-1:0]  out_tdata_q;
  logic [COLS-1:0]     win_prev_q, win_cur_q, win_next_q;

  logic [IDX_W-1:0]    in_idx;
  logic [CELLS_W-1:0]  in_cells;
  kind_e               in_kind;
  logic [8:0]          in_idx_ext;
  logic                in_range;
  logic [AW-1:0]       in_row;
  logic [63:0]         in_wide;
  logic                in_fire;

  logic                mem_we;
  logic [MAW-1:0]      mem_waddr, mem_raddr;
  logic [COLS-1:0]     mem_wdata, mem_rdata;
  logic [AW-1:0]       rd_row;
  logic [COLS-1:0]     rd_word;
  logic [63:0]         rd_wide;
  logic [CW-1:0]       km1, km4;
  logic [AW-1:0]       step_rrow, step_wrow;
  logic                shift_en;
  logic [COLS-1:0]     life_row;
  logic                out_load;

  assign in_idx     = s_axis_tdata[IDX_W-1:0];
  assign in_cells   = s_axis_tdata[IDX_W+CELLS_W-1:IDX_W];
  assign in_kind    = kind_e'(s_axis_tuser);
  assign in_idx_ext = 9'(in_idx);
  assign in_range   = in_idx_ext < 9'(ROWS);
  assign in_row     = in_idx_ext[AW-1:0];
  assign in_wide    = 64'(in_cells);
  assign in_fire    = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);

  // Step sequence: read rows ROWS-1, 0 .. ROWS-1, 0; write row k-4 from k = 4
  assign km1 = k_q - CW'(1);
  assign km4 = k_q - CW'(4);
  assign step_wrow = km4[AW-1:0];
  assign shift_en  = (state_q == ST_STEP) && (k_q != '0) && (k_q <= CW'(ROWS + 2));

  always_comb begin
    if (k_q == '0) begin
      step_rrow = AW'(ROWS - 1);
    end else if (k_q == CW'(ROWS + 1)) begin
      step_rrow = '0;
    end else begin
      step_rrow = km1[AW-1:0];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {bank_q, in_row};
    mem_wdata = in_wide[COLS-1:0];
    mem_raddr = {bank_q, in_row};
    rd_row    = in_row;
    if (state_q == ST_IDLE) begin
      mem_we = in_fire && (in_kind == KIND_WRITE) && in_range;
    end else if (state_q == ST_STEP) begin
      mem_raddr = {bank_q, step_rrow};
      rd_row    = step_rrow;
      if (k_q >= CW'(4)) begin
        mem_we    = 1'b1;
        mem_waddr = {~bank_q, step_wrow};
        mem_wdata = life_row;
      end
    end
  end

  lgen_mem #(
    .AW (MAW),
    .DW (COLS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  // Rows never written since reset read as zero
  assign rd_word = rvalid_q ? mem_rdata : '0;
  assign rd_wide = 64'(rd_word);

  lgen_rule #(
    .COLS (COLS)
  ) u_rule (
    .row_above_i (win_prev_q),
    .row_mid_i   (win_cur_q),
    .row_below_i (win_next_q),
    .row_next_o  (life_row)
  );

  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      win_prev_q <= win_cur_q;
      win_cur_q  <= win_next_q;
      win_next_q <= rd_word;
    end
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      k_q          <= '0;
      bank_q       <= 1'b0;
      valid_q      <= '0;
      rvalid_q     <= 1'b0;
      rd_inrange_q <= 1'b0;
      res_idx_q    <= '0;
      res_data_q   <= '0;
      out_valid_q  <= 1'b0;
      out_tdata_q  <= '0;
    end else begin
      rvalid_q <= valid_q[rd_row];

      // Drop the result once taken, unless a new one loads in the same cycle
      if (out_valid_q && m_axis_tready && !out_load) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (in_kind)
              KIND_WRITE: begin
                res_idx_q  <= in_idx;
                res_data_q <= in_cells;
                if (in_range) begin
                  valid_q[in_row] <= 1'b1;
                end
                state_q <= ST_DONE;
              end
              KIND_READ: begin
                res_idx_q    <= in_idx;
                rd_inrange_q <= in_range;
                state_q      <= ST_RDATA;
              end
              KIND_STEP: begin
                res_idx_q  <= '0;
                res_data_q <= '0;
                k_q        <= '0;
                state_q    <= ST_STEP;
              end
              default: begin
                res_idx_q  <= '0;
                res_data_q <= '0;
                state_q    <= ST_DONE;
              end
            endcase
          end
        end
        ST_RDATA: begin
          res_data_q <= rd_inrange_q ? rd_wide[CELLS_W-1:0] : '0;
          state_q    <= ST_DONE;
        end
        ST_STEP: begin
          k_q <= k_q + CW'(1);
          if (k_q == CW'(ROWS + 3)) begin
            // new generation is complete in the other bank
            bank_q  <= ~bank_q;
            valid_q <= '1;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_tdata_q <= {PadW'(0), res_data_q, res_idx_q};
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;

endmodule
